// ===== design/lfsr_matrix_jump_ahead_assert.svh =====
// ----------------------------------------------------------------------------
// LFSR jump-ahead assertion macros
// Shared property wrappers, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LFSR_MATRIX_JUMP_AHEAD_ASSERT_SVH
`define LFSR_MATRIX_JUMP_AHEAD_ASSERT_SVH

// Plain property, checked at every edge outside reset
`define LMJA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition at one edge implies a consequence at the next edge
`define LMJA_ASSERT_NEXT(lbl, pre, post, msg) \
  `LMJA_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== design/lmja_pkg.sv =====
// ----------------------------------------------------------------------------
// LFSR jump-ahead package
// Widths, reset values, codes and helper functions shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmja_pkg;

  localparam int unsigned StateBits = 48;
  localparam int unsigned CntW      = $clog2(StateBits);
  localparam int unsigned SqW       = 6;
  localparam int unsigned CfgIdxW   = 2;

  typedef logic [StateBits-1:0] row_t;

  localparam row_t            TapsReset = 48'hCE0044C101CD;
  localparam logic [CntW-1:0] LastIdx   = CntW'(StateBits - 1);

  // Item actions
  localparam logic ActRebuild = 1'b0;
  localparam logic ActJump    = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTaps      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSquarings = 2'd1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_PREP,
    OP_STEP,
    OP_COMMIT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP,
    ST_STEP,
    ST_COMMIT,
    ST_JUMP,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    cell_op_e op;
    logic     init;
  } ctl_t;

  // Rotate a row left by n places
  function automatic row_t rotl(row_t x, int unsigned n);
    logic [2*StateBits-1:0] d;
    d = {x, x};
    return d[2*StateBits-1-n -: StateBits];
  endfunction

  // Companion matrix row r (r >= 1): entry (r, r-1), a plain downward shift
  function automatic row_t comp_row(int unsigned r);
    return row_t'(1) << (StateBits - r);
  endfunction

endpackage

// ===== design/lfsr_matrix_jump_ahead.sv =====
// Jump: accepted in idle, one lap of the cell ring (one row per cycle at
//   cell 0), then into the output register; the next item waits for idle.
// Rebuild: loads the companion matrix, then each squaring is a prepare,
//   one lap of the ring and a commit; with no squarings it goes to finish.
// Reset: taps and squarings take their reset values, and the first cycle
//   after reset loads the companion matrix before the first item is taken.
// ----------------------------------------------------------------------------
// LFSR matrix jump-ahead engine
// Holds a 48x48 GF(2) matrix in a ring of row cells, rebuilds it as a power
// of the LFSR companion matrix and advances a state by multiplying with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfsr_matrix_jump_ahead (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [lmja_pkg::StateBits-1:0] state_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lmja_pkg::StateBits-1:0] state_out_o,
  input  logic                          cfg_we_i,
  input  logic [lmja_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lmja_pkg::StateBits-1:0] cfg_data_i
);

  lmja_pkg::row_t               taps_q;
  logic [lmja_pkg::SqW-1:0]     sq_q;
  lmja_pkg::ctl_t               ctl;
  lmja_pkg::row_t               rows [lmja_pkg::StateBits];

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= lmja_pkg::TapsReset;
      sq_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmja_pkg::CfgTaps:      taps_q <= cfg_data_i;
        lmja_pkg::CfgSquarings: sq_q   <= cfg_data_i[lmja_pkg::SqW-1:0];
        default: begin
          // ignore
        end
      endcase
    end
  end

  // Ring of row cells: cell j takes its row from cell j+1
  for (genvar j = 0; j < lmja_pkg::StateBits; j++) begin : g_cell
    localparam int unsigned Next = (j + 1) % lmja_pkg::StateBits;
    lmja_pkg::row_t load_row;

    if (j == 0) begin : g_top_row
      assign load_row = ctl.init ? lmja_pkg::TapsReset : taps_q;
    end else begin : g_shift_row
      assign load_row = lmja_pkg::comp_row(j);
    end

    lmja_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (ctl.op),
      .row_in_i   (rows[Next]),
      .load_row_i (load_row),
      .sel_load_i (lmja_pkg::rotl(rows[j], j)),
      .row_o      (rows[j])
    );
  end

  lmja_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .state_in_i  (state_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .state_out_o (state_out_o),
    .squarings_i (sq_q),
    .row0_i      (rows[0]),
    .ctl_o       (ctl)
  );

endmodule

// ===== design/lmja_cell.sv =====
// ----------------------------------------------------------------------------
// LFSR jump-ahead matrix cell
// Holds one circulating matrix row plus a stationary accumulator and
// column selector for squaring; hands its row to the next cell each step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lmja_cell (
  input  logic              clk_i,
  input  lmja_pkg::cell_op_e op_i,
  input  lmja_pkg::row_t    row_in_i,
  input  lmja_pkg::row_t    load_row_i,
  input  lmja_pkg::row_t    sel_load_i,
  output lmja_pkg::row_t    row_o
);

  lmja_pkg::row_t row_q;
  lmja_pkg::row_t acc_q;
  lmja_pkg::row_t sel_q;

  // Matrix datapath, no reset: the controller loads it after reset
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      lmja_pkg::OP_LOAD: begin
        row_q <= load_row_i;
      end
      lmja_pkg::OP_PREP: begin
        acc_q <= '0;
        sel_q <= sel_load_i;
      end
      lmja_pkg::OP_STEP: begin
        // take the neighbour's row, add the passing row where selected
        row_q <= row_in_i;
        acc_q <= acc_q ^ (sel_q[lmja_pkg::StateBits-1] ? row_q : '0);
        sel_q <= {sel_q[lmja_pkg::StateBits-2:0], sel_q[lmja_pkg::StateBits-1]};
      end
      lmja_pkg::OP_COMMIT: begin
        row_q <= acc_q;
      end
      default: begin
        // hold
      end
    endcase
  end

  assign row_o = row_q;

endmodule

// ===== design/lmja_ctrl.sv =====
// ----------------------------------------------------------------------------
// LFSR jump-ahead controller
// Sequences the cell row for rebuild and jump items, gathers the jump
// result one bit per row and holds it in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lfsr_matrix_jump_ahead_assert.svh"

module lmja_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        action_i,
  input  lmja_pkg::row_t              state_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lmja_pkg::row_t              state_out_o,
  input  logic [lmja_pkg::SqW-1:0]    squarings_i,
  input  lmja_pkg::row_t              row0_i,
  output lmja_pkg::ctl_t              ctl_o
);

  lmja_pkg::ctrl_state_e         state_q, state_d;
  logic [lmja_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [lmja_pkg::SqW-1:0]      sq_cnt_q, sq_cnt_d;
  logic                          out_valid_q, out_valid_d;
  lmja_pkg::row_t                stv_q, stv_d;
  lmja_pkg::row_t                res_q, res_d;
  lmja_pkg::row_t                out_data_q, out_data_d;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lmja_pkg::ST_INIT;
      cnt_q       <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sq_cnt_q    <= sq_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    stv_q      <= stv_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  // Next state and cell commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sq_cnt_d    = sq_cnt_q;
    stv_d       = stv_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    ctl_o.op    = lmja_pkg::OP_HOLD;
    ctl_o.init  = 1'b0;

    unique case (state_q)
      lmja_pkg::ST_INIT: begin
        // load the companion matrix of the reset taps
        ctl_o.op   = lmja_pkg::OP_LOAD;
        ctl_o.init = 1'b1;
        state_d    = lmja_pkg::ST_IDLE;
      end
      lmja_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d    = '0;
          stv_d    = state_in_i;
          cnt_d    = '0;
          sq_cnt_d = '0;
          if (action_i == lmja_pkg::ActJump) begin
            state_d = lmja_pkg::ST_JUMP;
          end else begin
            ctl_o.op = lmja_pkg::OP_LOAD;
            state_d  = (squarings_i == '0) ? lmja_pkg::ST_FINISH : lmja_pkg::ST_PREP;
          end
        end
      end
      lmja_pkg::ST_PREP: begin
        ctl_o.op = lmja_pkg::OP_PREP;
        cnt_d    = '0;
        state_d  = lmja_pkg::ST_STEP;
      end
      lmja_pkg::ST_STEP: begin
        // one full lap of the rows builds every product row
        ctl_o.op = lmja_pkg::OP_STEP;
        if (cnt_q == lmja_pkg::LastIdx) begin
          state_d = lmja_pkg::ST_COMMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lmja_pkg::ST_COMMIT: begin
        ctl_o.op = lmja_pkg::OP_COMMIT;
        if (lmja_pkg::SqW'(sq_cnt_q + 1'b1) == squarings_i) begin
          state_d = lmja_pkg::ST_FINISH;
        end else begin
          sq_cnt_d = sq_cnt_q + 1'b1;
          state_d  = lmja_pkg::ST_PREP;
        end
      end
      lmja_pkg::ST_JUMP: begin
        // row k passes cell 0 at step k and gives result bit 47-k
        ctl_o.op = lmja_pkg::OP_STEP;
        res_d    = {res_q[lmja_pkg::StateBits-2:0], ^(row0_i & stv_q)};
        if (cnt_q == lmja_pkg::LastIdx) begin
          state_d = lmja_pkg::ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      lmja_pkg::ST_FINISH: begin
        // hand the beat over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = lmja_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lmja_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign state_out_o = out_data_q;

  `LMJA_ASSERT_NEXT(a_jump_len, (state_q == lmja_pkg::ST_JUMP) && (cnt_q == lmja_pkg::LastIdx), state_q == lmja_pkg::ST_FINISH, "jump ran past the last row")
  `LMJA_ASSERT_NEXT(a_rebuild_start, in_valid_i && in_ready_o && (action_i == lmja_pkg::ActRebuild), (state_q == lmja_pkg::ST_PREP) || (state_q == lmja_pkg::ST_FINISH), "rebuild did not start squaring or finish")
  `LMJA_ASSERT(a_commit_bound, (state_q == lmja_pkg::ST_COMMIT) |-> (sq_cnt_q < squarings_i), "squaring count overran")
  `LMJA_ASSERT_NEXT(a_finish_out, (state_q == lmja_pkg::ST_FINISH) && !out_valid_q, out_valid_q && (state_q == lmja_pkg::ST_IDLE), "finished result not presented")

endmodule
